@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL; integer_radix_to_ascii_core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

@@ sv/itoa_pkg.sv @@
package itoa_pkg;

    localparam int DIGIT_W = 6;
    localparam int BASE_W  = 6;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    localparam logic [BASE_W-1:0] BASE_RAW = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ERR = 6'd1;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;

    typedef struct packed {
        logic               done;
        logic               quo_zero;
        logic [DIGIT_W-1:0] digit;
    } t_div_stat;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CH_ZERO + CHAR_W'(d);
        end else begin
            c = CH_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ sv/itoa_store.sv @@
module itoa_store #(
    parameter int DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(DEPTH)-1:0]           i_waddr,
    input  logic [itoa_pkg::DIGIT_W-1:0]       i_wdata,
    input  logic                               i_re,
    input  logic [$clog2(DEPTH)-1:0]           i_raddr,
    output logic [itoa_pkg::DIGIT_W-1:0]       o_rdata
);

    logic [itoa_pkg::DIGIT_W-1:0] r_mem [DEPTH];
    logic [itoa_pkg::DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/itoa_div.sv @@
module itoa_div #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [VALUE_BITS-1:0]         i_dividend,
    input  logic [itoa_pkg::BASE_W-1:0]   i_base,
    output itoa_pkg::t_div_stat           o_stat
);

    localparam int NB = (VALUE_BITS + 7) / 8;
    localparam int DW = NB * 8;
    localparam int CW = (NB > 1) ? $clog2(NB) : 1;

    logic                           r_run;
    logic [DW-1:0]                  r_dvd;
    logic [itoa_pkg::DIGIT_W-1:0]   r_rem;
    logic [itoa_pkg::BASE_W-1:0]    r_base;
    logic [CW-1:0]                  r_cyc;

    logic [DW-1:0]                  n_dvd;
    logic [7:0]                     w_top;
    logic [7:0]                     w_q;
    logic [itoa_pkg::DIGIT_W-1:0]   w_rem;
    logic [itoa_pkg::DIGIT_W:0]     w_t;
    logic                           w_last;
    logic                           w_zero;

    // one byte of long division per cycle: eight compare-subtract steps
    always_comb begin
        w_top = r_dvd[DW-1 -: 8];
        w_rem = r_rem;
        w_q   = '0;
        w_t   = '0;
        for (int i = 7; i >= 0; i--) begin
            w_t = {w_rem, w_top[i]};
            if (w_t >= {1'b0, r_base}) begin
                w_rem  = itoa_pkg::DIGIT_W'(w_t - {1'b0, r_base});
                w_q[i] = 1'b1;
            end else begin
                w_rem  = w_t[itoa_pkg::DIGIT_W-1:0];
            end
        end
        n_dvd = (r_dvd << 8) | DW'(w_q);
    end

    assign w_last = (r_cyc == CW'(NB - 1));
    assign w_zero = (n_dvd == '0);

    assign o_stat.done     = r_run && w_last;
    assign o_stat.quo_zero = w_zero;
    assign o_stat.digit    = w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cyc <= '0;
        end else if (i_load) begin
            r_run <= 1'b1;
            r_cyc <= '0;
        end else if (r_run) begin
            if (w_last) begin
                r_cyc <= '0;
                r_run <= !w_zero;
            end else begin
                r_cyc <= r_cyc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd  <= DW'(i_dividend);
            r_rem  <= '0;
            r_base <= i_base;
        end else if (r_run) begin
            r_dvd <= n_dvd;
            r_rem <= w_last ? '0 : w_rem;
        end
    end

endmodule

@@ sv/integer_radix_to_ascii_core.sv @@
// Channel   Direction  Handshake             Payload
// command   in         start high, busy low  i_mode, i_value, i_base
// result    out        o_strobe, one cycle   o_char_code, o_last, o_error
//
// Base 0 and base 1 give their single item in the cycle after start.
// Other bases: the byte-wide divider finds each digit and writes it to the digit
// store; the digits are then read back one per cycle, most significant first,
// through the store's read register and the output register. Once the divider
// starts, busy stays high until the last item is registered at the outputs.
// Reset is synchronous and active low; the receiver cannot stall.
`include "assert_macros.svh"

module integer_radix_to_ascii_core #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [31:0]                       i_value,
    input  logic [itoa_pkg::BASE_W-1:0]       i_base,
    output logic                              o_strobe,
    output logic [itoa_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last,
    output logic                              o_error
);

    localparam int AW = $clog2(VALUE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [AW:0]                    r_nd, n_nd;
    logic [AW:0]                    r_ptr, n_ptr;
    logic                           r_rd_vld, n_rd_vld;
    logic                           r_rd_last, n_rd_last;
    logic                           r_strobe, n_strobe;
    logic [itoa_pkg::CHAR_W-1:0]    r_char, n_char;
    logic                           r_last, n_last;
    logic                           r_error, n_error;

    logic                           w_acc;
    logic [VALUE_BITS-1:0]          w_v;
    logic [VALUE_BITS-1:0]          w_mag;
    logic                           w_neg;
    logic                           w_load;
    logic                           w_we;
    logic                           w_re;
    logic [AW:0]                    w_rd_idx;
    logic [itoa_pkg::DIGIT_W-1:0]   w_rdata;
    itoa_pkg::t_div_stat            w_div;

    assign busy   = (r_state != S_IDLE) || r_rd_vld;
    assign w_acc  = start && !busy;
    assign w_v    = VALUE_BITS'(i_value);
    assign w_neg  = i_mode && (i_base == itoa_pkg::BASE_DEC) && w_v[VALUE_BITS-1];
    assign w_mag  = w_neg ? (~w_v + 1'b1) : w_v;
    assign w_rd_idx = r_ptr - 1'b1;

    itoa_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_dividend (w_mag),
        .i_base     (i_base),
        .o_stat     (w_div)
    );

    itoa_store #(
        .DEPTH (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_nd[AW-1:0]),
        .i_wdata (w_div.digit),
        .i_re    (w_re),
        .i_raddr (w_rd_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_nd      = r_nd;
        n_ptr     = r_ptr;
        n_rd_vld  = 1'b0;
        n_rd_last = r_rd_last;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_last    = r_last;
        n_error   = 1'b0;
        w_load    = 1'b0;
        w_we      = 1'b0;
        w_re      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_base == itoa_pkg::BASE_RAW) begin
                        n_strobe = 1'b1;
                        n_char   = i_value[7:0];
                        n_last   = 1'b1;
                    end else if (i_base == itoa_pkg::BASE_ERR) begin
                        n_strobe = 1'b1;
                        n_char   = itoa_pkg::CH_NUL;
                        n_last   = 1'b1;
                        n_error  = 1'b1;
                    end else begin
                        if (w_neg) begin
                            n_strobe = 1'b1;
                            n_char   = itoa_pkg::CH_MINUS;
                            n_last   = 1'b0;
                        end else if (w_mag == '0) begin
                            n_strobe = 1'b1;
                            n_char   = itoa_pkg::CH_ZERO;
                            n_last   = 1'b1;
                        end
                        if (w_mag != '0) begin
                            w_load  = 1'b1;
                            n_nd    = '0;
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    w_we = 1'b1;
                    n_nd = r_nd + 1'b1;
                    if (w_div.quo_zero) begin
                        n_ptr   = r_nd + 1'b1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                w_re      = 1'b1;
                n_rd_vld  = 1'b1;
                n_rd_last = (r_ptr == (AW+1)'(1));
                n_ptr     = w_rd_idx;
                if (r_ptr == (AW+1)'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_rd_vld) begin
            n_strobe = 1'b1;
            n_char   = itoa_pkg::digit_char(w_rdata);
            n_last   = r_rd_last;
            n_error  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nd      <= n_nd;
        r_ptr     <= n_ptr;
        r_rd_last <= n_rd_last;
        r_char    <= n_char;
        r_last    <= n_last;
        r_error   <= n_error;
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_error     = r_error;

    `ASSERT_CLK(a_err_is_last, i_clk, i_rst_n, (o_strobe && o_error) |-> o_last, "error item not last")
    `ASSERT_CLK(a_emit_reads, i_clk, i_rst_n, (r_state == S_EMIT) |=> r_rd_vld, "emit without read")
    `ASSERT_CLK(a_read_shows, i_clk, i_rst_n, r_rd_vld |=> o_strobe, "read digit dropped")
    `ASSERT_NEVER(a_div_in_div, i_clk, i_rst_n, w_div.done && (r_state != S_DIV), "digit outside divide")

endmodule
